FILE: src/assert_macros.svh
// assertion macros included by the inverse kinematics core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition in a cycle implies a consequence in the same cycle
`define ASSERT_IMPLY(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("assertion failed");

// condition in a cycle implies a consequence in the next cycle
`define ASSERT_NEXT(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
    else $error("assertion failed");

`endif

FILE: src/tlik_pkg.sv
// shared constants, tables and helpers of the two-link inverse kinematics core
package tlik_pkg;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_UPPER_LEN  = 3'd0,
    REG_LOWER_LEN  = 3'd1,
    REG_TOOL_LEN   = 3'd2,
    REG_BASE_X     = 3'd3,
    REG_BASE_Z     = 3'd4,
    REG_TOOL_PITCH = 3'd5,
    REG_SHLD_OFS   = 3'd6
  } reg_index_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 20;

  // register reset values
  localparam logic [17:0] UPPER_LEN_RST  = 18'd16581;
  localparam logic [17:0] LOWER_LEN_RST  = 18'd12681;
  localparam logic [17:0] TOOL_LEN_RST   = 18'd13107;
  localparam logic [19:0] BASE_X_RST     = 20'd0;
  localparam logic [19:0] BASE_Z_RST     = 20'd61604;
  localparam logic [19:0] TOOL_PITCH_RST = 20'd0;
  localparam logic [19:0] SHLD_OFS_RST   = 20'd102892;

  // angles in q30 radians
  localparam logic signed [34:0] Q30_PI      = 35'sd3373259426;
  localparam logic signed [34:0] Q30_HALF_PI = 35'sd1686629713;
  localparam logic signed [34:0] Q30_ROUND   = 35'sd8192;

  // last iteration index of each loop
  localparam logic [4:0] SQRT_LAST  = 5'd21;
  localparam logic [4:0] DIV_LAST   = 5'd15;
  localparam logic [4:0] CORDIC_LAST = 5'd29;

  // cordic arctangent table, q30
  localparam logic [29:0] ATAN_TAB [30] = '{
    30'h3243F6A8, 30'h1DAC6705, 30'h0FADBAFC, 30'h07F56EA6, 30'h03FEAB76,
    30'h01FFD55B, 30'h00FFFAAA, 30'h007FFF55, 30'h003FFFEA, 30'h001FFFFD,
    30'h000FFFFF, 30'h0007FFFF, 30'h0003FFFF, 30'h0001FFFF, 30'h0000FFFF,
    30'h00007FFF, 30'h00003FFF, 30'h00001FFF, 30'h00000FFF, 30'h000007FF,
    30'h000003FF, 30'h000001FF, 30'h000000FF, 30'h0000007F, 30'h0000003F,
    30'h0000001F, 30'h0000000F, 30'h00000008, 30'h00000004, 30'h00000002
  };

  // saturate a command to the 20-bit signed range
  function automatic logic signed [19:0] sat_cmd(input logic signed [22:0] v);
    logic signed [19:0] r;
    if (v > 23'sd524287) begin
      r = 20'sd524287;
    end else if (v < -23'sd524288) begin
      r = -20'sd524288;
    end else begin
      r = v[19:0];
    end
    return r;
  endfunction

endpackage

FILE: src/tlik_channels.sv
// valid/ready channel interfaces for targets and joint commands
interface tlik_target_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] target_x;
  logic signed [19:0] target_z;
  modport source (output valid, target_x, target_z, input ready);
  modport sink (input valid, target_x, target_z, output ready);
endinterface

interface tlik_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [19:0] shoulder_cmd;
  logic signed [19:0] elbow_cmd;
  logic signed [19:0] wrist_cmd;
  logic               reachable;
  modport source (output valid, shoulder_cmd, elbow_cmd, wrist_cmd, reachable, input ready);
  modport sink (input valid, shoulder_cmd, elbow_cmd, wrist_cmd, reachable, output ready);
endinterface

FILE: src/two_link_planar_inverse_kinematics_core.sv
// one target at a time; every target runs a 22-step square root, a reachable one also
// up to two 16-step divides, up to two more roots and up to three cordic angle runs (30
// steps plus up to 38 normalize shifts each); squares and products share one 22x22
// multiplier; the next target can be taken in the cycle after the command is accepted
// reset (synchronous, active high) restores register defaults and zero held
// commands
`include "assert_macros.svh"

module two_link_planar_inverse_kinematics_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_we,
  input  logic [tlik_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [tlik_pkg::CFG_DATA_W-1:0] cfg_data,
  tlik_target_if.sink                target,
  tlik_cmd_if.source                 command
);
  import tlik_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE, S_ABS, S_MXX, S_MZZ, S_SUM, S_SQRT, S_SQDONE, S_M11, S_M22, S_M12,
    S_MS1, S_CHK, S_DIVSET, S_DIV, S_DIVDONE, S_ACSQ, S_ACSUB, S_VCHK, S_VNORM,
    S_VROT, S_VDONE, S_RND, S_CMD, S_OUT
  } state_t;

  typedef enum logic [1:0] {PH_DIST, PH_ELBOW, PH_BETA, PH_PSI} phase_t;

  // configuration registers
  logic [17:0]        upper_len, lower_len, tool_len;
  logic signed [19:0] base_x, base_z, tool_pitch, shoulder_ofs;

  // sequencer and datapath registers
  state_t             state;
  phase_t             phase;
  logic [4:0]         cnt;
  logic signed [21:0] dx, dz;
  logic [20:0]        adx, adz;
  logic [43:0]        s2, p;
  logic [21:0]        s;
  logic [35:0]        l1sq, l2sq, l12;
  logic [39:0]        sl1;
  logic [43:0]        sq_v;
  logic [24:0]        sq_rem;
  logic [21:0]        sq_root;
  logic signed [45:0] dnum;
  logic [41:0]        dden;
  logic [45:0]        drem;
  logic               dneg;
  logic [15:0]        dq;
  logic [16:0]        ac;
  logic               cneg;
  logic signed [41:0] vx, vy;
  logic signed [34:0] vz;
  logic signed [34:0] th2, beta, psi;
  logic signed [19:0] t1, t2;
  logic signed [19:0] held_shoulder, held_elbow, held_wrist;
  logic               reach;

  // config write port
  always_ff @(posedge clk) begin
    if (rst) begin
      upper_len    <= UPPER_LEN_RST;
      lower_len    <= LOWER_LEN_RST;
      tool_len     <= TOOL_LEN_RST;
      base_x       <= BASE_X_RST;
      base_z       <= BASE_Z_RST;
      tool_pitch   <= TOOL_PITCH_RST;
      shoulder_ofs <= SHLD_OFS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_UPPER_LEN:  upper_len    <= cfg_data[17:0];
        REG_LOWER_LEN:  lower_len    <= cfg_data[17:0];
        REG_TOOL_LEN:   tool_len     <= cfg_data[17:0];
        REG_BASE_X:     base_x       <= cfg_data;
        REG_BASE_Z:     base_z       <= cfg_data;
        REG_TOOL_PITCH: tool_pitch   <= cfg_data;
        REG_SHLD_OFS:   shoulder_ofs <= cfg_data;
        default: ;
      endcase
    end
  end

  // shared multiplier operand select
  logic [21:0] mul_a, mul_b;
  logic [43:0] mprod;
  always_comb begin
    unique case (state)
      S_MXX:   begin mul_a = {1'b0, adx};  mul_b = {1'b0, adx};  end
      S_MZZ:   begin mul_a = {1'b0, adz};  mul_b = {1'b0, adz};  end
      S_M11:   begin mul_a = {4'b0, upper_len}; mul_b = {4'b0, upper_len}; end
      S_M22:   begin mul_a = {4'b0, lower_len}; mul_b = {4'b0, lower_len}; end
      S_M12:   begin mul_a = {4'b0, upper_len}; mul_b = {4'b0, lower_len}; end
      S_MS1:   begin mul_a = s;            mul_b = {4'b0, upper_len}; end
      S_ACSQ:  begin mul_a = {5'b0, ac};   mul_b = {5'b0, ac};   end
      default: begin mul_a = '0;           mul_b = '0;           end
    endcase
  end
  assign mprod = mul_a * mul_b;

  // square root digit step
  logic [26:0] rem_sh, trial;
  assign rem_sh = {sq_rem, sq_v[43:42]};
  assign trial  = {3'b0, sq_root, 2'b01};

  // divider step and setup magnitudes
  logic [45:0] dmag, drem_sh;
  assign dmag    = dnum[45] ? 46'(-dnum) : 46'(dnum);
  assign drem_sh = {drem[44:0], 1'b0};

  // cordic shifted operands
  logic signed [41:0] xs, ys;
  logic signed [34:0] atan_v, ang;
  assign xs     = vx >>> cnt;
  assign ys     = vy >>> cnt;
  assign atan_v = $signed({5'b0, ATAN_TAB[cnt]});
  assign ang    = (phase != PH_BETA && cneg) ? Q30_PI - vz : vz;

  // front-end differences
  logic signed [21:0] dx_in, dz_in;
  assign dx_in = 22'(target.target_x) - $signed({4'b0, tool_len}) - 22'(base_x);
  assign dz_in = 22'(target.target_z) - 22'(base_z);

  // rounding sums
  logic signed [34:0] t1_sum, t2_sum;
  assign t1_sum = beta + psi + Q30_ROUND;
  assign t2_sum = th2 + Q30_ROUND;

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      phase         <= PH_DIST;
      cnt           <= '0;
      held_shoulder <= '0;
      held_elbow    <= '0;
      held_wrist    <= '0;
      reach         <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (target.valid) begin
            dx    <= dx_in;
            dz    <= dz_in;
            state <= S_ABS;
          end
        end
        S_ABS: begin
          adx   <= dx[21] ? 21'(-dx) : dx[20:0];
          adz   <= dz[21] ? 21'(-dz) : dz[20:0];
          state <= S_MXX;
        end
        S_MXX: begin
          s2    <= mprod;
          state <= S_MZZ;
        end
        S_MZZ: begin
          p     <= mprod;
          state <= S_SUM;
        end
        S_SUM: begin
          s2      <= s2 + p;
          sq_v    <= s2 + p;
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= SQRT_LAST;
          phase   <= PH_DIST;
          state   <= S_SQRT;
        end
        // one root bit per cycle
        S_SQRT: begin
          if (rem_sh >= trial) begin
            sq_rem  <= 25'(rem_sh - trial);
            sq_root <= {sq_root[20:0], 1'b1};
          end else begin
            sq_rem  <= rem_sh[24:0];
            sq_root <= {sq_root[20:0], 1'b0};
          end
          sq_v <= {sq_v[41:0], 2'b00};
          cnt  <= cnt - 5'd1;
          if (cnt == '0) state <= S_SQDONE;
        end
        S_SQDONE: begin
          if (phase == PH_DIST) begin
            s     <= sq_root;
            state <= S_M11;
          end else begin
            vx    <= 42'(ac);
            vy    <= 42'(sq_root);
            state <= S_VCHK;
          end
        end
        S_M11: begin l1sq <= mprod[35:0]; state <= S_M22; end
        S_M22: begin l2sq <= mprod[35:0]; state <= S_M12; end
        S_M12: begin l12  <= mprod[35:0]; state <= S_MS1; end
        S_MS1: begin sl1  <= mprod[39:0]; state <= S_CHK; end
        // reach test, then elbow cosine
        S_CHK: begin
          if (s > 22'(upper_len) + 22'(lower_len)) begin
            reach <= 1'b0;
            state <= S_OUT;
          end else begin
            reach <= 1'b1;
            dnum  <= $signed(46'(l1sq) + 46'(l2sq) - 46'(s2));
            dden  <= {5'b0, l12, 1'b0};
            phase <= PH_ELBOW;
            state <= S_DIVSET;
          end
        end
        S_DIVSET: begin
          dneg <= dnum[45];
          if (dmag >= 46'(dden)) begin
            ac    <= 17'h10000;
            cneg  <= dnum[45];
            state <= S_ACSQ;
          end else begin
            drem  <= dmag;
            dq    <= '0;
            cnt   <= DIV_LAST;
            state <= S_DIV;
          end
        end
        // one quotient bit per cycle
        S_DIV: begin
          if (drem_sh >= 46'(dden)) begin
            drem <= drem_sh - 46'(dden);
            dq   <= {dq[14:0], 1'b1};
          end else begin
            drem <= drem_sh;
            dq   <= {dq[14:0], 1'b0};
          end
          cnt <= cnt - 5'd1;
          if (cnt == '0) state <= S_DIVDONE;
        end
        S_DIVDONE: begin
          ac    <= {1'b0, dq};
          cneg  <= dneg && (dq != '0);
          state <= S_ACSQ;
        end
        S_ACSQ: begin
          p     <= mprod;
          state <= S_ACSUB;
        end
        S_ACSUB: begin
          sq_v    <= 44'h1_0000_0000 - p;
          sq_rem  <= '0;
          sq_root <= '0;
          cnt     <= SQRT_LAST;
          state   <= S_SQRT;
        end
        // vectoring special cases
        S_VCHK: begin
          vz <= '0;
          if (vy == '0) begin
            state <= S_VDONE;
          end else if (vx == '0) begin
            vz    <= Q30_HALF_PI;
            state <= S_VDONE;
          end else begin
            state <= S_VNORM;
          end
        end
        S_VNORM: begin
          if (vx[41:38] == '0 && vy[41:38] == '0) begin
            vx <= vx <<< 1;
            vy <= vy <<< 1;
          end else begin
            cnt   <= '0;
            state <= S_VROT;
          end
        end
        // one cordic rotation per cycle
        S_VROT: begin
          if (!vy[41]) begin
            vx <= vx + ys;
            vy <= vy - xs;
            vz <= vz + atan_v;
          end else begin
            vx <= vx - ys;
            vy <= vy + xs;
            vz <= vz - atan_v;
          end
          cnt <= cnt + 5'd1;
          if (cnt == CORDIC_LAST) state <= S_VDONE;
        end
        S_VDONE: begin
          unique case (phase)
            PH_ELBOW: begin
              th2   <= ang - Q30_PI;
              vx    <= 42'(adx);
              vy    <= 42'(adz);
              phase <= PH_BETA;
              state <= S_VCHK;
            end
            PH_BETA: begin
              beta <= ang;
              if (s != '0 && upper_len != '0) begin
                dnum  <= $signed(46'(s2) + 46'(l1sq) - 46'(l2sq));
                dden  <= {1'b0, sl1, 1'b0};
                phase <= PH_PSI;
                state <= S_DIVSET;
              end else begin
                psi   <= '0;
                state <= S_RND;
              end
            end
            PH_PSI: begin
              psi   <= ang;
              state <= S_RND;
            end
            PH_DIST: state <= S_RND;
          endcase
        end
        S_RND: begin
          t1    <= t1_sum[33:14];
          t2    <= t2_sum[33:14];
          state <= S_CMD;
        end
        S_CMD: begin
          held_shoulder <= sat_cmd(23'(shoulder_ofs) - 23'(t1));
          held_elbow    <= sat_cmd(23'(t2));
          held_wrist    <= sat_cmd(23'(t1) + 23'(t2) - 23'(tool_pitch));
          state         <= S_OUT;
        end
        S_OUT: begin
          if (command.ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // channel outputs
  assign target.ready         = (state == S_IDLE);
  assign command.valid        = (state == S_OUT);
  assign command.shoulder_cmd = held_shoulder;
  assign command.elbow_cmd    = held_elbow;
  assign command.wrist_cmd    = held_wrist;
  assign command.reachable    = reach;

  // checks
  `ASSERT_IMPLY(a_no_overlap, clk, rst, command.valid, !target.ready)
  `ASSERT_NEXT(a_accept_starts, clk, rst, target.valid && target.ready, state == S_ABS)
  `ASSERT_IMPLY(a_sqrt_cnt, clk, rst, state == S_SQRT, cnt <= SQRT_LAST)
  `ASSERT_IMPLY(a_div_cnt, clk, rst, state == S_DIV, cnt <= DIV_LAST)

endmodule

FILE: tb/two_link_planar_inverse_kinematics_core_tb.sv
// self-checking testbench of the two-link inverse kinematics core
`timescale 1ns / 1ps

module two_link_planar_inverse_kinematics_core_tb;
  import tlik_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES = 400;

  typedef struct packed {
    logic signed [19:0] shoulder;
    logic signed [19:0] elbow;
    logic signed [19:0] wrist;
    logic               reachable;
  } joint_cmd_t;

  typedef enum logic { ROW_TARGET, ROW_WRITE } row_kind_t;

  typedef struct {
    row_kind_t         kind;
    logic signed [19:0] x;        // target x, or write data
    logic signed [19:0] z;
    logic [CFG_IDX_W-1:0] index;
    bit                 typed;    // expected command given in the row
    joint_cmd_t         cmd;
  } stim_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  tlik_target_if tgt();
  tlik_cmd_if cmd();

  two_link_planar_inverse_kinematics_core dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .target(tgt), .command(cmd)
  );

  // register and held-command copy of the arm solver
  longint arm_upper, arm_lower, arm_tool, arm_base_x, arm_base_z, arm_pitch, arm_offset;
  longint held_sh, held_el, held_wr;

  joint_cmd_t pending_cmds[$];
  bit         pending_typed[$];
  joint_cmd_t typed_cmds[$];
  int mismatches = 0;
  int tx_idle_pct = 0;
  int rx_idle_pct = 0;
  int rx_hold_cycles = 0;
  int quiet_cycles = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b = b >> 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  // atan2 of non-negative operands by vectoring cordic, q30
  function automatic longint vector_angle(longint x, longint y);
    longint z, xs, ys;
    z = 0;
    if (y == 0) return 0;
    if (x == 0) return longint'(Q30_HALF_PI);
    while (x < (64'sd1 <<< 38) && y < (64'sd1 <<< 38)) begin
      x = x * 2;
      y = y * 2;
    end
    for (int i = 0; i < 30; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y >= 0) begin
        x = x + ys; y = y - xs; z = z + longint'(ATAN_TAB[i]);
      end else begin
        x = x - ys; y = y + xs; z = z - longint'(ATAN_TAB[i]);
      end
    end
    return z;
  endfunction

  function automatic longint clamped_cosine(longint num, longint den);
    longint c;
    c = (num * 65536) / den;
    return c > 65536 ? 65536 : (c < -65536 ? -65536 : c);
  endfunction

  function automatic longint arc_cosine(longint c);
    longint a;
    a = vector_angle(c < 0 ? -c : c, longint'(floor_root(64'd4294967296 - c * c)));
    return c < 0 ? longint'(Q30_PI) - a : a;
  endfunction

  function automatic longint q30_round(longint v);
    return (v + 8192) >>> 14;
  endfunction

  function automatic longint clip_cmd(longint v);
    return v > 524287 ? 524287 : (v < -524288 ? -524288 : v);
  endfunction

  // solve one target, update held commands
  function automatic joint_cmd_t solve_arm(logic signed [19:0] tx, logic signed [19:0] tz);
    longint dx, dz, s2, s, c2, th2, beta, psi, t1, t2;
    joint_cmd_t r;
    dx = longint'(tx) - arm_tool - arm_base_x;
    dz = longint'(tz) - arm_base_z;
    s2 = dx * dx + dz * dz;
    s = longint'(floor_root(s2));
    r.reachable = 1'b0;
    if (s <= arm_upper + arm_lower) begin
      if (arm_upper * arm_lower == 0)
        c2 = (arm_upper * arm_upper + arm_lower * arm_lower - s2) >= 0 ? 65536 : -65536;
      else
        c2 = clamped_cosine(arm_upper * arm_upper + arm_lower * arm_lower - s2,
                            2 * arm_upper * arm_lower);
      th2 = arc_cosine(c2) - longint'(Q30_PI);
      beta = vector_angle(dx < 0 ? -dx : dx, dz < 0 ? -dz : dz);
      psi = 0;
      if (s != 0 && arm_upper != 0)
        psi = arc_cosine(clamped_cosine(s2 + arm_upper * arm_upper - arm_lower * arm_lower,
                                        2 * s * arm_upper));
      t1 = q30_round(beta + psi);
      t2 = q30_round(th2);
      held_sh = clip_cmd(arm_offset - t1);
      held_el = clip_cmd(t2);
      held_wr = clip_cmd(t1 + t2 - arm_pitch);
      r.reachable = 1'b1;
    end
    r.shoulder = held_sh[19:0];
    r.elbow = held_el[19:0];
    r.wrist = held_wr[19:0];
    return r;
  endfunction

  // monitor: predict on target transactions, check command transactions
  always @(posedge clk) begin
    joint_cmd_t want, got;
    bit moved;
    moved = 1'b0;
    if (!rst) begin
      if (tgt.valid && tgt.ready) begin
        want = solve_arm(tgt.target_x, tgt.target_z);
        if (pending_typed.pop_front()) want = typed_cmds.pop_front();
        pending_cmds.push_back(want);
        moved = 1'b1;
      end
      if (cmd.valid && cmd.ready) begin
        moved = 1'b1;
        got = '{cmd.shoulder_cmd, cmd.elbow_cmd, cmd.wrist_cmd, cmd.reachable};
        if (pending_cmds.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected command transaction %p", got);
        end else begin
          want = pending_cmds.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("command mismatch: expected %p actual %p", want, got);
          end
        end
      end
      quiet_cycles <= moved ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // receiver ready with random idling and a long hold-off
  initial begin
    cmd.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_cycles > 0) begin
        rx_hold_cycles--;
        cmd.ready = 1'b0;
      end else begin
        cmd.ready = ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [19:0] d);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = d;
    case (idx)
      REG_UPPER_LEN:  arm_upper = longint'(d[17:0]);
      REG_LOWER_LEN:  arm_lower = longint'(d[17:0]);
      REG_TOOL_LEN:   arm_tool = longint'(d[17:0]);
      REG_BASE_X:     arm_base_x = longint'($signed(d));
      REG_BASE_Z:     arm_base_z = longint'($signed(d));
      REG_TOOL_PITCH: arm_pitch = longint'($signed(d));
      REG_SHLD_OFS:   arm_offset = longint'($signed(d));
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic wait_drained();
    while (pending_cmds.size() != 0) @(negedge clk);
  endtask

  // offer one target, held until its transaction
  task automatic send_target(logic signed [19:0] x, logic signed [19:0] z, bit typed,
                             joint_cmd_t c);
    while ($urandom_range(99) < tx_idle_pct) @(negedge clk);
    pending_typed.push_back(typed);
    if (typed) typed_cmds.push_back(c);
    tgt.valid = 1'b1;
    tgt.target_x = x;
    tgt.target_z = z;
    do @(posedge clk); while (!tgt.ready);
    @(negedge clk);
    tgt.valid = 1'b0;
  endtask

  function automatic logic [19:0] random_target(longint reach, longint offs);
    longint d;
    if ($urandom_range(99) < 25) return 20'($urandom);
    d = longint'($urandom_range(0, 32'(2 * reach))) - reach;
    return 20'(d + offs);
  endfunction

  stim_row_t rows[$];

  task automatic add_target(logic signed [19:0] x, logic signed [19:0] z);
    rows.push_back('{ROW_TARGET, x, z, REG_UNUSED, 1'b0, '0});
  endtask

  task automatic add_write(logic [CFG_IDX_W-1:0] idx, logic [19:0] d);
    rows.push_back('{ROW_WRITE, d, 20'sd0, idx, 1'b0, '0});
  endtask

  initial begin
    logic [19:0] rx, rz;
    longint reach;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    tgt.valid = 1'b0;
    tgt.target_x = '0;
    tgt.target_z = '0;
    arm_upper = 16581; arm_lower = 12681; arm_tool = 13107;
    arm_base_x = 0; arm_base_z = 61604; arm_pitch = 0; arm_offset = 102892;
    held_sh = 0; held_el = 0; held_wr = 0;

    // out of reach straight after reset repeats zero commands
    rows.push_back('{ROW_TARGET, 20'sd524287, 20'sd524287, REG_UNUSED, 1'b1, '0});
    rows.push_back('{ROW_TARGET, -20'sd524288, -20'sd524288, REG_UNUSED, 1'b1, '0});
    add_target(20'sd13107, 20'sd61604);            // zero distance
    add_target(20'sd13107, 20'sd90866);            // exactly at full reach
    add_target(20'sd42370, 20'sd61604);            // one step beyond reach, held
    add_target(20'sd30000, 20'sd50000);
    add_target(-20'sd2000, 20'sd70000);
    add_target(20'sd13200, 20'sd61600);            // tiny distance, clamped cosine
    add_write(REG_UNUSED, 20'hFFFFF);              // ignored index
    add_target(20'sd20000, 20'sd60000);
    add_write(REG_UPPER_LEN, 20'd0);               // zero upper link
    add_target(20'sd20000, 20'sd61604);
    add_target(20'sd13107, 20'sd61604);
    add_write(REG_UPPER_LEN, 20'd262143);
    add_write(REG_LOWER_LEN, 20'd262143);
    add_write(REG_TOOL_LEN, 20'd262143);
    add_write(REG_BASE_X, 20'h80000);
    add_write(REG_BASE_Z, 20'h7FFFF);
    add_write(REG_TOOL_PITCH, 20'h80000);
    add_write(REG_SHLD_OFS, 20'h7FFFF);
    add_target(20'sd524287, -20'sd524288);
    add_target(-20'sd524288, 20'sd524287);
    add_target(20'sd0, 20'sd0);
    add_write(REG_LOWER_LEN, 20'd0);
    add_write(REG_TOOL_PITCH, 20'h7FFFF);
    add_write(REG_SHLD_OFS, 20'h80000);
    add_target(20'sd100000, 20'sd300000);
    add_target(-20'sd300000, 20'sd524287);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    tx_idle_pct = 17;
    rx_idle_pct = 52;

    // directed table
    foreach (rows[i]) begin
      if (rows[i].kind == ROW_WRITE) begin
        wait_drained();
        write_reg(rows[i].index, rows[i].x);
      end else begin
        send_target(rows[i].x, rows[i].z, rows[i].typed, rows[i].cmd);
      end
    end

    // random targets, arm geometry rewritten every hundred (reset values first)
    for (int n = 0; n < 800; n++) begin
      if (n == 267) begin
        tx_idle_pct = 52; rx_idle_pct = 17;
      end else if (n == 534) begin
        tx_idle_pct = 0; rx_idle_pct = 0;
      end
      if (n == 300) rx_hold_cycles = 1500;
      if (n % 100 == 0) begin
        wait_drained();
        if (n == 0) begin
          write_reg(REG_UPPER_LEN, 20'd16581);
          write_reg(REG_LOWER_LEN, 20'd12681);
          write_reg(REG_TOOL_LEN, 20'd13107);
          write_reg(REG_BASE_X, 20'd0);
          write_reg(REG_BASE_Z, 20'd61604);
          write_reg(REG_TOOL_PITCH, 20'd0);
          write_reg(REG_SHLD_OFS, 20'd102892);
        end else begin
          write_reg(REG_UPPER_LEN, 20'($urandom_range(n == 700 ? 262143 : 60000)));
          write_reg(REG_LOWER_LEN, 20'($urandom_range(n == 700 ? 262143 : 60000)));
          write_reg(REG_TOOL_LEN, 20'($urandom_range(262143)));
          write_reg(REG_BASE_X, 20'($urandom_range(200000)) - 20'd100000);
          write_reg(REG_BASE_Z, 20'($urandom_range(200000)) - 20'd100000);
          write_reg(REG_TOOL_PITCH, 20'($urandom));
          write_reg(REG_SHLD_OFS, 20'($urandom));
        end
      end
      reach = arm_upper + arm_lower + 2;
      rx = random_target(reach, arm_tool + arm_base_x);
      rz = random_target(reach, arm_base_z);
      send_target(rx, rz, 1'b0, '0);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (mismatches == 0 && pending_cmds.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
